// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define BBF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bbf assertion failed");

// Consequent must hold in the cycle after the antecedent
`define BBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bbf assertion failed");

`endif

// ----- design/bbf_pkg.sv -----
// ----------------------------------------------------------------------------
// bbf_pkg
// Types and fixed widths of the bounding-box fit block.
// ----------------------------------------------------------------------------
package bbf_pkg;

	localparam int COORD_W   = 16;  // Q8.8 input coordinate
	localparam int OUT_W     = 24;  // Q16.8 result
	localparam int CFG_W     = 13;  // window register width
	localparam int CFG_IDX_W = 1;
	localparam int EXT_W     = 16;  // box extent, raw Q8.8 count
	localparam int SUM_W     = 17;  // min + max
	localparam int DIFF_W    = 18;  // 2*p - (min + max)
	localparam int NUM_W     = 41;  // 9 * W * 2^24
	localparam int DEN_W     = 20;  // 10 * extent
	localparam int SCALE_W   = 37;  // scale with 16 fraction bits
	localparam int SLO_W     = 19;  // low slice of the scale for the multiplier
	localparam int SHI_W     = SCALE_W - SLO_W;
	localparam int MOP_W     = SLO_W + 1;
	localparam int PROD_W    = DIFF_W + MOP_W;
	localparam int ACC_W     = 56;
	localparam int OUT_SHIFT = 17;

	localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd480;

	localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;
	localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 1'd1;

	typedef enum logic [3:0] {
		S_LOAD,
		S_DIVX_GO,
		S_DIVX_WAIT,
		S_DIVY_GO,
		S_DIVY_WAIT,
		S_FETCH,
		S_MULX_GO,
		S_MULX_WAIT,
		S_MULY_GO,
		S_MULY_WAIT,
		S_EMIT
	} bbf_state_t;

endpackage

// ----- design/bbf_if.sv -----
// ----------------------------------------------------------------------------
// bbf_in_if / bbf_out_if
// Valid/ready channels for point words and result words.
// ----------------------------------------------------------------------------
interface bbf_in_if;
	import bbf_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] x_in;
	logic signed [COORD_W-1:0] y_in;
	logic                      last_in;

	modport source (output valid, x_in, y_in, last_in, input ready);
	modport sink   (input valid, x_in, y_in, last_in, output ready);
endinterface

interface bbf_out_if;
	import bbf_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] x_out;
	logic signed [OUT_W-1:0] y_out;
	logic                    last_out;
	logic                    points_dropped;

	modport source (output valid, x_out, y_out, last_out, points_dropped, input ready);
	modport sink   (input valid, x_out, y_out, last_out, points_dropped, output ready);
endinterface

// ----- design/bbf_div.sv -----
// ----------------------------------------------------------------------------
// bbf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bbf_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bbf_pkg::NUM_W-1:0]    num,
	input  logic [bbf_pkg::DEN_W-1:0]    den,
	output logic                         done,
	output logic [bbf_pkg::NUM_W-1:0]    quot
);
	import bbf_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;   // dividend shifts out, quotient shifts in
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   trial;
	logic             fits;
	logic [DEN_W:0]   diff;

	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		fits  = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

// ----- design/bbf_mac.sv -----
// ----------------------------------------------------------------------------
// bbf_mac
// Scales one centred value: two passes through a 18x20 multiplier, then
// round to nearest and saturate to Q16.8.
// ----------------------------------------------------------------------------
module bbf_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [bbf_pkg::DIFF_W-1:0] d,
	input  logic [bbf_pkg::SCALE_W-1:0]       s,
	output logic                              done,
	output logic signed [bbf_pkg::OUT_W-1:0]  res
);
	import bbf_pkg::*;

	localparam int TOP_W = ACC_W - OUT_SHIFT - OUT_W + 1;

	logic                     busy_q;
	logic                     done_q;
	logic [1:0]               ph_q;
	logic signed [DIFF_W-1:0] d_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [OUT_W-1:0]  res_q;

	logic signed [MOP_W-1:0]  mop;
	logic signed [PROD_W-1:0] prod;
	logic [ACC_W-1:0]         rnd;
	logic [TOP_W-1:0]         top;
	logic signed [OUT_W-1:0]  sat;

	always_comb begin
		// low slice on the first pass, high slice on the second
		mop  = (ph_q == 2'd0) ? $signed({1'b0, s[SLO_W-1:0]})
		                      : $signed({2'b00, s[SCALE_W-1:SLO_W]});
		prod = d_q * mop;
		rnd  = acc_q + (ACC_W'(1) << (OUT_SHIFT - 1));
		top  = rnd[ACC_W-1:ACC_W-TOP_W];
		if (top == {TOP_W{rnd[ACC_W-1]}})
			sat = $signed(rnd[OUT_SHIFT+OUT_W-1:OUT_SHIFT]);
		else if (rnd[ACC_W-1])
			sat = {1'b1, {(OUT_W-1){1'b0}}};
		else
			sat = {1'b0, {(OUT_W-1){1'b1}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= '0;
		end else begin
			done_q <= busy_q && !start && (ph_q == 2'd3);
			if (start) begin
				busy_q <= 1'b1;
				ph_q   <= '0;
			end else if (busy_q) begin
				ph_q <= ph_q + 1'b1;
				if (ph_q == 2'd3)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q <= d;
		end else if (busy_q) begin
			case (ph_q)
				2'd0: begin
					prod_q <= prod;
				end
				2'd1: begin
					acc_q  <= ACC_W'(prod_q);
					prod_q <= prod;
				end
				2'd2: begin
					acc_q <= acc_q + {prod_q[ACC_W-SLO_W-1:0], {SLO_W{1'b0}}};
				end
				default: begin
					res_q <= sat;
				end
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ----- design/bounding_box_fit_to_window.sv -----
// ----------------------------------------------------------------------------
// bounding_box_fit_to_window
// Collects a set of points, fits their bounding box to the window with a 0.9
// margin and streams the centred, scaled points out in arrival order.
// ----------------------------------------------------------------------------
//  channel   dir  word                                          when taken
//  points    in   x_in, y_in, last_in                           valid & ready
//  results   out  x_out, y_out, last_out, points_dropped        valid & ready
//  cfg       in   cfg_index, cfg_data                           cfg_we
//
//  A point is taken whenever points.valid is high while a set is being loaded.
//  The last point starts up to two divisions on the serial divider, one for
//  x and one for y, each skipped when that extent is zero.
//  Each stored point then passes through the shared multiplier, which makes
//  two passes for x and two for y, and waits out any output stall.
//  points.ready is low from the last point until the last word is taken.
//  Reset clears the box, the count and the window registers (640 x 480);
//  the point store needs no clearing.
// ----------------------------------------------------------------------------
module bounding_box_fit_to_window #(
	parameter int MAX_POINTS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	bbf_in_if.sink                          points,
	bbf_out_if.source                       results,
	input  logic                            cfg_we,
	input  logic [bbf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bbf_pkg::CFG_W-1:0]       cfg_data
);
	import bbf_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int MW = 2 * COORD_W;

	bbf_state_t state_q, state_d;

	logic [CFG_W-1:0] width_q, height_q;

	logic [MW-1:0] mem [MAX_POINTS];
	logic [MW-1:0] rd_q;

	logic [CW-1:0]             count_q;
	logic [CW-1:0]             idx_q;
	logic signed [COORD_W-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic                      ovf_q;
	logic [SCALE_W-1:0]        s_q;
	logic                      have_q;
	logic signed [OUT_W-1:0]   xres_q;

	logic                      out_valid_q;
	logic signed [OUT_W-1:0]   x_out_q, y_out_q;
	logic                      last_out_q, dropped_q;

	// sequencer controls
	logic accept, div_start, mac_start, emit_take;

	logic                      room;
	logic [SUM_W-1:0]          ext_x, ext_y;
	logic signed [SUM_W-1:0]   sum_x, sum_y;
	logic signed [DIFF_W-1:0]  dx, dy;
	logic [NUM_W-1:0]          div_num;
	logic [DEN_W-1:0]          div_den;
	logic [EXT_W-1:0]          div_ext;
	logic [CFG_W-1:0]          div_win;
	logic [NUM_W-1:0]          div_q;
	logic                      div_done;
	logic                      mac_done;
	logic signed [OUT_W-1:0]   mac_res;
	logic                      last_pt;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_WIDTH:  width_q  <= cfg_data;
				REG_WINDOW_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------ datapath
	always_comb begin
		room    = count_q < CW'(MAX_POINTS);
		ext_x   = {max_x_q[COORD_W-1], max_x_q} - {min_x_q[COORD_W-1], min_x_q};
		ext_y   = {max_y_q[COORD_W-1], max_y_q} - {min_y_q[COORD_W-1], min_y_q};
		sum_x   = {min_x_q[COORD_W-1], min_x_q} + {max_x_q[COORD_W-1], max_x_q};
		sum_y   = {min_y_q[COORD_W-1], min_y_q} + {max_y_q[COORD_W-1], max_y_q};
		dx      = {rd_q[MW-1], rd_q[MW-1:COORD_W], 1'b0}
		          - {sum_x[SUM_W-1], sum_x};
		dy      = {rd_q[COORD_W-1], rd_q[COORD_W-1:0], 1'b0}
		          - {sum_y[SUM_W-1], sum_y};
		// the y division is launched only from its own state
		div_win = (state_q == S_DIVY_GO) ? height_q : width_q;
		div_ext = (state_q == S_DIVY_GO) ? ext_y[EXT_W-1:0] : ext_x[EXT_W-1:0];
		div_num = {((17'(div_win) << 3) + 17'(div_win)), 24'd0};
		div_den = (DEN_W'(div_ext) << 3) + (DEN_W'(div_ext) << 1);
		last_pt = (idx_q + 1'b1) == count_q;
	end

	bbf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_q)
	);

	bbf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.d      ((state_q == S_MULY_GO) ? dy : dx),
		.s      (s_q),
		.done   (mac_done),
		.res    (mac_res)
	);

	// ----------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_LOAD;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		accept    = 1'b0;
		div_start = 1'b0;
		mac_start = 1'b0;
		emit_take = 1'b0;
		case (state_q)
			S_LOAD: begin
				accept = points.valid;
				if (points.valid && points.last_in)
					state_d = S_DIVX_GO;
			end
			S_DIVX_GO: begin
				if (ext_x != '0) begin
					div_start = 1'b1;
					state_d   = S_DIVX_WAIT;
				end else begin
					state_d = S_DIVY_GO;
				end
			end
			S_DIVX_WAIT: begin
				if (div_done)
					state_d = S_DIVY_GO;
			end
			S_DIVY_GO: begin
				if (ext_y != '0) begin
					div_start = 1'b1;
					state_d   = S_DIVY_WAIT;
				end else begin
					state_d = S_FETCH;
				end
			end
			S_DIVY_WAIT: begin
				if (div_done)
					state_d = S_FETCH;
			end
			S_FETCH: begin
				state_d = S_MULX_GO;
			end
			S_MULX_GO: begin
				mac_start = 1'b1;
				state_d   = S_MULX_WAIT;
			end
			S_MULX_WAIT: begin
				if (mac_done)
					state_d = S_MULY_GO;
			end
			S_MULY_GO: begin
				mac_start = 1'b1;
				state_d   = S_MULY_WAIT;
			end
			S_MULY_WAIT: begin
				if (mac_done)
					state_d = S_EMIT;
			end
			S_EMIT: begin
				if (results.ready) begin
					emit_take = 1'b1;
					state_d   = last_out_q ? S_LOAD : S_FETCH;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	// -------------------------------------------------------- set tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			min_x_q <= COORD_MAX;
			min_y_q <= COORD_MAX;
			max_x_q <= COORD_MIN;
			max_y_q <= COORD_MIN;
			ovf_q   <= 1'b0;
			have_q  <= 1'b0;
		end else begin
			if (accept) begin
				if (room) begin
					count_q <= count_q + 1'b1;
					if (points.x_in < min_x_q) min_x_q <= points.x_in;
					if (points.x_in > max_x_q) max_x_q <= points.x_in;
					if (points.y_in < min_y_q) min_y_q <= points.y_in;
					if (points.y_in > max_y_q) max_y_q <= points.y_in;
				end else begin
					ovf_q <= 1'b1;
				end
				have_q <= 1'b0;
			end
			if (state_q == S_DIVX_WAIT && div_done)
				have_q <= 1'b1;
			if (emit_take) begin
				// drop the set once its last word has gone
				if (last_out_q) begin
					count_q <= '0;
					idx_q   <= '0;
					min_x_q <= COORD_MAX;
					min_y_q <= COORD_MAX;
					max_x_q <= COORD_MIN;
					max_y_q <= COORD_MIN;
					ovf_q   <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	// scale: zero unless an axis with extent supplies one
	always_ff @(posedge clk) begin
		if (accept)
			s_q <= '0;
		else if (div_done && state_q == S_DIVX_WAIT)
			s_q <= div_q[SCALE_W-1:0];
		else if (div_done && state_q == S_DIVY_WAIT &&
		         (!have_q || div_q[SCALE_W-1:0] < s_q))
			s_q <= div_q[SCALE_W-1:0];
	end

	// ---------------------------------------------------------- point store
	always_ff @(posedge clk) begin
		if (accept && room)
			mem[count_q[AW-1:0]] <= {points.x_in, points.y_in};
		rd_q <= mem[idx_q[AW-1:0]];
	end

	// -------------------------------------------------------- output word
	always_ff @(posedge clk) begin
		if (state_q == S_MULX_WAIT && mac_done)
			xres_q <= mac_res;
		if (state_q == S_MULY_WAIT && mac_done) begin
			x_out_q    <= xres_q;
			y_out_q    <= mac_res;
			last_out_q <= last_pt;
			dropped_q  <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == S_MULY_WAIT && mac_done)
			out_valid_q <= 1'b1;
		else if (emit_take)
			out_valid_q <= 1'b0;
	end

	assign points.ready           = (state_q == S_LOAD);
	assign results.valid          = out_valid_q;
	assign results.x_out          = x_out_q;
	assign results.y_out          = y_out_q;
	assign results.last_out       = last_out_q;
	assign results.points_dropped = dropped_q;

endmodule

// ----- design/bbf_checker.sv -----
// ----------------------------------------------------------------------------
// bbf_checker
// Port-level checks on the load and emit phases of the fit block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bbf_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_last,
	input logic out_valid,
	input logic out_ready,
	input logic out_last
);

	// loading and emitting never overlap
	`BBF_ASSERT_SAME(a_no_overlap, clk, arst_n, in_ready, !out_valid)

	// a point that does not close the set leaves the input open
	`BBF_ASSERT_NEXT(a_keep_loading, clk, arst_n, in_valid && in_ready && !in_last, in_ready)

	// once the last word is taken the next set may load
	`BBF_ASSERT_NEXT(a_reopen, clk, arst_n, out_valid && out_ready && out_last, in_ready)

	// a stalled word stays offered
	`BBF_ASSERT_NEXT(a_hold_valid, clk, arst_n, out_valid && !out_ready, out_valid)

endmodule

bind bounding_box_fit_to_window bbf_checker u_bbf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (points.valid),
	.in_ready  (points.ready),
	.in_last   (points.last_in),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_last  (results.last_out)
);
